// File: design/nld_pkg.sv
// Package for the nearest level debouncer.
// Holds the field widths, the parameter defaults, the shared types and the default level function.
// No dependencies.
package nld_pkg;

	localparam int unsigned VOLTS_W            = 16;
	localparam int unsigned LEVEL_W            = 3;
	localparam int unsigned RUN_W              = 4;
	localparam int unsigned INDEX_W            = 3;
	localparam int unsigned REG_COUNT          = 5;
	localparam int unsigned MAX_LEVELS         = 8;
	localparam int unsigned LEVEL_COUNT_DEF    = 5;
	localparam int unsigned DEBOUNCE_COUNT_DEF = 3;
	localparam int unsigned DEFAULT_STEP_DEF   = 5000;

	typedef logic [VOLTS_W-1:0] volts_t;
	typedef logic [LEVEL_W-1:0] level_t;
	typedef logic [RUN_W-1:0]   run_t;
	typedef logic [INDEX_W-1:0] reg_index_t;

	typedef struct packed {
		logic   seen_first;
		level_t held_level;
		level_t candidate_level;
		run_t   candidate_run;
	} dbn_state_t;

	function automatic volts_t default_volts(int unsigned idx, int unsigned step);
		return volts_t'(idx * step);
	endfunction

endpackage

// File: design/nld_if.sv
// Stream interfaces of the nearest level debouncer: samples in, levels out.
// Depends on nld_pkg for the payload types.
interface nld_sample_if;
	logic            valid;
	logic            ready;
	nld_pkg::volts_t sample_volts;

	modport source (output valid, output sample_volts, input ready);
	modport sink   (input valid, input sample_volts, output ready);
endinterface

interface nld_level_if;
	logic            valid;
	logic            ready;
	nld_pkg::level_t stable_level;

	modport source (output valid, output stable_level, input ready);
	modport sink   (input valid, input stable_level, output ready);
endinterface

// File: design/nearest_level_debouncer.sv
// Nearest level debouncer: one sample transaction in, one stable level transaction out.
// Each sample is matched to the nearest calibrated level and the reported level changes only
// after the same nearest level is seen DEBOUNCE_COUNT times in a row; the first sample after
// reset sets it at once. The block takes one transaction per cycle while the output is not
// stalled; each sample passes through an input register, then the parallel distance compare and
// debounce update into the result register. Level registers may be written only while no
// transaction is in flight; indexes 5 and up are ignored.
// Depends on nld_pkg, nld_if, nld_level_bank, nld_nearest and nld_debounce.
module nearest_level_debouncer #(
	parameter int unsigned LEVEL_COUNT    = nld_pkg::LEVEL_COUNT_DEF,
	parameter int unsigned DEBOUNCE_COUNT = nld_pkg::DEBOUNCE_COUNT_DEF,
	parameter int unsigned DEFAULT_STEP   = nld_pkg::DEFAULT_STEP_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                wr_en,
	input  nld_pkg::reg_index_t wr_index,
	input  nld_pkg::volts_t     wr_data,
	nld_sample_if.sink          samples,
	nld_level_if.source         levels
);

	nld_pkg::volts_t level_volts [LEVEL_COUNT];
	nld_pkg::volts_t sample_s1;
	logic            valid_s1;
	logic            valid_q;
	nld_pkg::level_t stable_q;
	logic            advance;
	logic            accept;
	nld_pkg::level_t nearest;
	nld_pkg::level_t held_next;

	assign advance       = !valid_q || levels.ready;
	assign samples.ready = !valid_s1 || advance;
	assign accept        = samples.valid && samples.ready;

	nld_level_bank #(
		.LEVEL_COUNT  (LEVEL_COUNT),
		.DEFAULT_STEP (DEFAULT_STEP)
	) u_bank (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (wr_en),
		.wr_index (wr_index),
		.wr_data  (wr_data),
		.levels   (level_volts)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			sample_s1 <= samples.sample_volts;
		end
	end

	nld_nearest #(
		.LEVEL_COUNT (LEVEL_COUNT)
	) u_nearest (
		.sample_volts (sample_s1),
		.levels       (level_volts),
		.nearest      (nearest)
	);

	nld_debounce #(
		.DEBOUNCE_COUNT (DEBOUNCE_COUNT)
	) u_debounce (
		.clk       (clk),
		.arst_n    (arst_n),
		.commit    (valid_s1 && advance),
		.nearest   (nearest),
		.held_next (held_next)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (advance) begin
			valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s1 && advance) begin
			stable_q <= held_next;
		end
	end

	assign levels.valid        = valid_q;
	assign levels.stable_level = stable_q;

endmodule

// File: design/nld_level_bank.sv
// Calibrated level voltages: writable registers for the first levels, fixed defaults beyond them.
// Depends on nld_pkg.
module nld_level_bank #(
	parameter int unsigned LEVEL_COUNT  = nld_pkg::LEVEL_COUNT_DEF,
	parameter int unsigned DEFAULT_STEP = nld_pkg::DEFAULT_STEP_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                wr_en,
	input  nld_pkg::reg_index_t wr_index,
	input  nld_pkg::volts_t     wr_data,
	output nld_pkg::volts_t     levels [LEVEL_COUNT]
);

	for (genvar i = 0; i < LEVEL_COUNT; i++) begin : g_level
		localparam nld_pkg::volts_t ResetVolts = nld_pkg::default_volts(i, DEFAULT_STEP);
		if (i < nld_pkg::REG_COUNT) begin : g_reg
			localparam nld_pkg::reg_index_t Index = (nld_pkg::INDEX_W)'(i);
			nld_pkg::volts_t level_q;

			always_ff @(posedge clk or negedge arst_n) begin
				if (!arst_n) begin
					level_q <= ResetVolts;
				end else if (wr_en && wr_index == Index) begin
					level_q <= wr_data;
				end
			end

			assign levels[i] = level_q;
		end else begin : g_fixed
			assign levels[i] = ResetVolts;
		end
	end

endmodule

// File: design/nld_nearest.sv
// Nearest level search by absolute difference, lowest index on a tie.
// Depends on nld_pkg.
module nld_nearest #(
	parameter int unsigned LEVEL_COUNT = nld_pkg::LEVEL_COUNT_DEF
) (
	input  nld_pkg::volts_t sample_volts,
	input  nld_pkg::volts_t levels [LEVEL_COUNT],
	output nld_pkg::level_t nearest
);

	nld_pkg::volts_t gap [LEVEL_COUNT];

	for (genvar i = 0; i < LEVEL_COUNT; i++) begin : g_gap
		assign gap[i] = (sample_volts >= levels[i]) ? sample_volts - levels[i]
		                                            : levels[i] - sample_volts;
	end

	always_comb begin
		nld_pkg::volts_t best_gap;
		nld_pkg::level_t best;
		best_gap = gap[0];
		best     = '0;
		for (int i = 1; i < LEVEL_COUNT; i++) begin
			if (gap[i] < best_gap) begin
				best_gap = gap[i];
				best     = nld_pkg::level_t'(i);
			end
		end
		nearest = best;
	end

endmodule

// File: design/nld_debounce.sv
// Debounce state of the nearest level: candidate run counter and held level.
// Depends on nld_pkg.
module nld_debounce #(
	parameter int unsigned DEBOUNCE_COUNT = nld_pkg::DEBOUNCE_COUNT_DEF
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            commit,
	input  nld_pkg::level_t nearest,
	output nld_pkg::level_t held_next
);

	localparam nld_pkg::run_t RunMax = nld_pkg::run_t'(DEBOUNCE_COUNT);

	nld_pkg::dbn_state_t state_q;
	nld_pkg::dbn_state_t state_d;

	always_comb begin
		state_d = state_q;
		if (!state_q.seen_first) begin
			state_d.seen_first      = 1'b1;
			state_d.held_level      = nearest;
			state_d.candidate_level = nearest;
			state_d.candidate_run   = RunMax;
		end else begin
			if (nearest == state_q.candidate_level) begin
				if (state_q.candidate_run < RunMax) begin
					state_d.candidate_run = state_q.candidate_run + 1'b1;
				end
			end else begin
				state_d.candidate_level = nearest;
				state_d.candidate_run   = nld_pkg::run_t'(1);
			end
			if (state_d.candidate_run >= RunMax) begin
				state_d.held_level = state_d.candidate_level;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= '0;
		end else if (commit) begin
			state_q <= state_d;
		end
	end

	assign held_next = state_d.held_level;

endmodule

// File: design/nld_checker.sv
// Port checker for the nearest level debouncer, attached to the top level by a bind.
// Depends on nld_pkg and the top level nearest_level_debouncer.
module nld_port_checker #(
	parameter int unsigned LEVEL_COUNT = nld_pkg::LEVEL_COUNT_DEF
) (
	input logic            clk,
	input logic            arst_n,
	input logic            in_ready,
	input logic            out_valid,
	input logic            out_ready,
	input nld_pkg::level_t stable_level
);

	localparam nld_pkg::level_t LastLevel = nld_pkg::level_t'(LEVEL_COUNT - 1);

	a_reset_empty: assert property (@(posedge clk) !arst_n |-> !out_valid)
		else $error("Result valid during reset.");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(stable_level))
		else $error("Stalled result transaction dropped or changed.");

	a_level_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> stable_level <= LastLevel)
		else $error("Reported level beyond the level count.");

	a_ready_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> in_ready)
		else $error("Sample transaction refused while the result register is empty.");

endmodule

bind nearest_level_debouncer nld_port_checker #(
	.LEVEL_COUNT (LEVEL_COUNT)
) u_nld_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.in_ready     (samples.ready),
	.out_valid    (levels.valid),
	.out_ready    (levels.ready),
	.stable_level (levels.stable_level)
);

// File: tb/nld_checker.sv
`timescale 1ns / 100ps
// Checker for the nearest level debouncer: watches the level writes and both streams.
// It predicts the stable level of each sample and compares it with each result.
// Depends on nld_pkg.
module nld_checker #(
	parameter int unsigned LEVEL_COUNT    = nld_pkg::LEVEL_COUNT_DEF,
	parameter int unsigned DEBOUNCE_COUNT = nld_pkg::DEBOUNCE_COUNT_DEF,
	parameter int unsigned DEFAULT_STEP   = nld_pkg::DEFAULT_STEP_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                wr_en,
	input  nld_pkg::reg_index_t wr_index,
	input  nld_pkg::volts_t     wr_data,
	input  logic                sample_valid,
	input  logic                sample_ready,
	input  nld_pkg::volts_t     sample_volts,
	input  logic                level_valid,
	input  logic                level_ready,
	input  nld_pkg::level_t     stable_level,
	output int unsigned         mismatches,
	output int unsigned         outstanding
);

	localparam nld_pkg::run_t       RunMax   = nld_pkg::run_t'(DEBOUNCE_COUNT);
	localparam nld_pkg::reg_index_t RegLimit = nld_pkg::reg_index_t'(nld_pkg::REG_COUNT);

	nld_pkg::volts_t cal_volts [nld_pkg::MAX_LEVELS];
	logic            have_first;
	nld_pkg::level_t shown_level;
	nld_pkg::level_t trial_level;
	nld_pkg::run_t   trial_run;
	nld_pkg::level_t pending_levels [$];
	nld_pkg::level_t want_level;
	nld_pkg::level_t new_level;

	function automatic nld_pkg::level_t closest_level(nld_pkg::volts_t v);
		nld_pkg::level_t best;
		nld_pkg::volts_t best_gap;
		nld_pkg::volts_t gap;
		best     = '0;
		best_gap = (v >= cal_volts[0]) ? v - cal_volts[0] : cal_volts[0] - v;
		for (int i = 1; i < LEVEL_COUNT && i < nld_pkg::MAX_LEVELS; i++) begin
			gap = (v >= cal_volts[i]) ? v - cal_volts[i] : cal_volts[i] - v;
			if (gap < best_gap) begin
				best_gap = gap;
				best     = nld_pkg::level_t'(i);
			end
		end
		return best;
	endfunction

	task automatic debounce_sample(input nld_pkg::volts_t v, output nld_pkg::level_t lvl);
		nld_pkg::level_t hit;
		hit = closest_level(v);
		if (!have_first) begin
			shown_level = hit;
			trial_level = hit;
			trial_run   = RunMax;
			have_first  = 1'b1;
		end else begin
			if (hit == trial_level) begin
				if (trial_run < RunMax)
					trial_run = trial_run + 1'b1;
			end else begin
				trial_level = hit;
				trial_run   = nld_pkg::run_t'(1);
			end
			if (trial_run >= RunMax)
				shown_level = trial_level;
		end
		lvl = shown_level;
	endtask

	task automatic report_mismatch(input string what);
		$display("%0t ns: %s", $time, what);
		mismatches++;
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < nld_pkg::MAX_LEVELS; i++)
				cal_volts[i] = nld_pkg::volts_t'(i * DEFAULT_STEP);
			have_first  = 1'b0;
			shown_level = '0;
			trial_level = '0;
			trial_run   = '0;
			pending_levels.delete();
			mismatches  = 0;
			outstanding = 0;
		end else begin
			if (wr_en && wr_index < RegLimit)
				cal_volts[wr_index] = wr_data;
			if (level_valid && level_ready) begin
				if (pending_levels.size() == 0) begin
					report_mismatch($sformatf("unexpected level transaction %0d", stable_level));
				end else begin
					want_level = pending_levels.pop_front();
					if (stable_level !== want_level)
						report_mismatch($sformatf("stable_level %0d, predicted %0d",
							stable_level, want_level));
				end
			end
			if (sample_valid && sample_ready) begin
				debounce_sample(sample_volts, new_level);
				pending_levels.push_back(new_level);
			end
			outstanding = pending_levels.size();
		end
	end

endmodule

// File: tb/testbench.sv
`timescale 1ns / 100ps
// Top of the nearest level debouncer testbench: clock, reset, level writes and stimulus.
// Depends on nld_pkg, nld_if, nearest_level_debouncer and nld_checker.
module testbench;

	localparam nld_pkg::reg_index_t LEVEL0_REG  = nld_pkg::reg_index_t'(0);
	localparam int                  VOLTS_MAX   = (1 << nld_pkg::VOLTS_W) - 1;
	localparam int                  PHASES      = 8;
	localparam int                  PHASE_ITEMS = 115;

	logic                clk;
	logic                arst_n;
	logic                wr_en;
	nld_pkg::reg_index_t wr_index;
	nld_pkg::volts_t     wr_data;
	int unsigned         mismatches;
	int unsigned         outstanding;
	nld_pkg::volts_t     cfg [nld_pkg::REG_COUNT];
	bit                  gaps_on;
	bit                  stalls_on;
	bit                  calm;
	bit                  hold_req;
	bit                  hold_taken;

	nld_sample_if samples ();
	nld_level_if  levels ();

	nearest_level_debouncer dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (wr_en),
		.wr_index (wr_index),
		.wr_data  (wr_data),
		.samples  (samples),
		.levels   (levels)
	);

	nld_checker checker_i (
		.clk          (clk),
		.arst_n       (arst_n),
		.wr_en        (wr_en),
		.wr_index     (wr_index),
		.wr_data      (wr_data),
		.sample_valid (samples.valid),
		.sample_ready (samples.ready),
		.sample_volts (samples.sample_volts),
		.level_valid  (levels.valid),
		.level_ready  (levels.ready),
		.stable_level (levels.stable_level),
		.mismatches   (mismatches),
		.outstanding  (outstanding)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	initial begin
		#2000000;
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

	initial begin
		levels.ready <= 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (hold_req && !hold_taken) begin
				hold_taken = 1'b1;
				levels.ready <= 1'b0;
				repeat (59) @(negedge clk);
			end else if (stalls_on && !calm && $urandom_range(0, 3) == 0) begin
				levels.ready <= 1'b0;
				repeat ($urandom_range(1, 3) - 1) @(negedge clk);
			end else begin
				levels.ready <= 1'b1;
			end
		end
	end

	task automatic send_sample(input nld_pkg::volts_t v);
		@(negedge clk);
		samples.valid        <= 1'b1;
		samples.sample_volts <= v;
		do @(posedge clk); while (!samples.ready);
		if (gaps_on && !calm && $urandom_range(0, 4) == 0) begin
			@(negedge clk);
			samples.valid <= 1'b0;
			repeat ($urandom_range(1, 3) - 1) @(negedge clk);
		end
	endtask

	task automatic drain;
		@(negedge clk);
		samples.valid <= 1'b0;
		while (outstanding != 0) @(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	task automatic write_level(input nld_pkg::reg_index_t idx, input nld_pkg::volts_t v);
		@(negedge clk);
		wr_en    <= 1'b1;
		wr_index <= idx;
		wr_data  <= v;
		@(negedge clk);
		wr_en    <= 1'b0;
		if (idx < nld_pkg::REG_COUNT)
			cfg[idx] = v;
	endtask

	task automatic set_levels(input nld_pkg::volts_t v0, input nld_pkg::volts_t v1,
		input nld_pkg::volts_t v2, input nld_pkg::volts_t v3, input nld_pkg::volts_t v4);
		write_level(LEVEL0_REG,                           v0);
		write_level(nld_pkg::reg_index_t'(LEVEL0_REG + 1), v1);
		write_level(nld_pkg::reg_index_t'(LEVEL0_REG + 2), v2);
		write_level(nld_pkg::reg_index_t'(LEVEL0_REG + 3), v3);
		write_level(nld_pkg::reg_index_t'(LEVEL0_REG + 4), v4);
	endtask

	function automatic nld_pkg::volts_t near_volts(nld_pkg::volts_t center,
		int unsigned spread);
		int v;
		v = int'(center) + int'($urandom_range(0, 2 * spread)) - int'(spread);
		if (v < 0)
			v = 0;
		else if (v > VOLTS_MAX)
			v = VOLTS_MAX;
		return nld_pkg::volts_t'(v);
	endfunction

	task automatic run_phase(input int unsigned items);
		int unsigned sent;
		int unsigned lvl;
		int unsigned len;
		int unsigned pick;
		sent = 0;
		while (sent < items) begin
			pick = $urandom_range(0, 9);
			if (pick < 7) begin
				lvl = $urandom_range(0, nld_pkg::REG_COUNT - 1);
				len = $urandom_range(1, nld_pkg::DEBOUNCE_COUNT_DEF + 2);
				repeat (len) send_sample(near_volts(cfg[lvl], $urandom_range(0, 300)));
				sent += len;
			end else if (pick < 9) begin
				send_sample(nld_pkg::volts_t'($urandom_range(0, VOLTS_MAX)));
				sent++;
			end else begin
				lvl = $urandom_range(0, nld_pkg::REG_COUNT - 2);
				send_sample(nld_pkg::volts_t'((int'(cfg[lvl]) + int'(cfg[lvl + 1])) / 2));
				sent++;
			end
		end
	endtask

	initial begin
		arst_n               = 1'b0;
		wr_en                = 1'b0;
		wr_index             = '0;
		wr_data              = '0;
		samples.valid        = 1'b0;
		samples.sample_volts = '0;
		gaps_on              = 1'b0;
		stalls_on            = 1'b0;
		calm                 = 1'b0;
		hold_req             = 1'b0;
		hold_taken           = 1'b0;
		for (int i = 0; i < nld_pkg::REG_COUNT; i++)
			cfg[i] = nld_pkg::volts_t'(i * nld_pkg::DEFAULT_STEP_DEF);
		repeat (10) @(negedge clk);
		arst_n = 1'b1;

		// Writes past the last level register must leave the default levels alone.
		write_level(nld_pkg::reg_index_t'(nld_pkg::REG_COUNT),     16'hFFFF);
		write_level(nld_pkg::reg_index_t'(nld_pkg::REG_COUNT + 1), 16'h0000);
		write_level(nld_pkg::reg_index_t'(nld_pkg::REG_COUNT + 2), 16'h5A5A);

		// The first sample takes effect at once, then runs, ties and saturation.
		send_sample(16'd12000);
		send_sample(16'd0);
		repeat (5) send_sample(16'hFFFF);
		repeat (2) send_sample(16'd2500);
		repeat (3) send_sample(16'd7500);
		repeat (4) send_sample(16'd17500);
		send_sample(16'd20000);
		send_sample(16'd9999);
		send_sample(16'd10001);
		send_sample(16'd10000);

		for (int ph = 0; ph < PHASES; ph++) begin
			if (ph > 0) begin
				drain();
				case (ph)
					1: set_levels(16'd0, 16'd0, 16'd0, 16'd0, 16'd0);
					2: set_levels(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
					3: set_levels(16'd0, 16'd16384, 16'd32768, 16'd49152, 16'hFFFF);
					4: set_levels(16'd60000, 16'd45000, 16'd30000, 16'd15000, 16'd100);
					5: set_levels(16'd1000, 16'd1000, 16'd30000, 16'd30000, 16'd64000);
					default: begin
						for (int i = 0; i < nld_pkg::REG_COUNT; i++)
							write_level(nld_pkg::reg_index_t'(LEVEL0_REG + i),
								nld_pkg::volts_t'($urandom_range(0, VOLTS_MAX)));
						write_level(nld_pkg::reg_index_t'(nld_pkg::REG_COUNT + 2), 16'hFFFF);
					end
				endcase
			end
			gaps_on   = $urandom_range(0, 3) != 0;
			stalls_on = $urandom_range(0, 3) != 0;
			calm      = (ph == PHASES - 1);
			if (ph == 3)
				hold_req = 1'b1;
			run_phase(PHASE_ITEMS);
		end

		@(negedge clk);
		samples.valid <= 1'b0;
		for (int n = 0; n < 20000 && outstanding != 0; n++) @(negedge clk);
		repeat (5) @(negedge clk);
		if (mismatches == 0 && outstanding == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule

// File: files.f
design/nld_pkg.sv
design/nld_if.sv
design/nld_level_bank.sv
design/nld_nearest.sv
design/nld_debounce.sv
design/nearest_level_debouncer.sv
design/nld_checker.sv
tb/nld_checker.sv
tb/testbench.sv
